// ----- sv/kpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types and constants for the keypad scan and debounce block.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int TIMER_W      = 16;
    localparam int ROW_W        = 2;
    localparam int COL_W        = 2;
    localparam int DRIVE_W      = 4;
    localparam int ROW_SLOTS    = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [TIMER_W-1:0] COLUMN_PERIOD_RST   = 16'd10;
    localparam logic [TIMER_W-1:0] DEBOUNCE_PERIOD_RST = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_PERIOD   = 1'b0,
        CFG_DEBOUNCE_PERIOD = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_EDGE = 1'b1
    } t_op;

    // first field in the highest bits
    typedef struct packed {
        logic               column_advanced;
        logic [DRIVE_W-1:0] column_drive;
        logic [COL_W-1:0]   key_column;
        logic [ROW_W-1:0]   key_row;
        logic               key_valid;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ----- sv/kpsd_core.sv -----
// ----------------------------------------------------------------------------
// kpsd_core
// Scan and debounce state: column dwell counter, active column, per-row
// debounce timers and the configuration registers. Produces one result per
// accepted beat: key report from the old state, column drive from the new.
// ----------------------------------------------------------------------------
module kpsd_core #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kpsd_pkg::TIMER_W-1:0]        i_cfg_data,
    input  logic                                i_accept,
    input  kpsd_pkg::t_op                       i_op,
    input  logic [kpsd_pkg::ROW_W-1:0]          i_row,
    output kpsd_pkg::t_result                   o_result
);
    import kpsd_pkg::*;

    // only rows 0..3 can be addressed by an edge beat
    localparam int NT = (ROW_COUNT < ROW_SLOTS) ? ROW_COUNT : ROW_SLOTS;
    localparam int CW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMN_COUNT - 1);

    logic [TIMER_W-1:0] r_col_period;
    logic [TIMER_W-1:0] r_deb_period;
    logic [CW-1:0]      r_column,  n_column;
    logic [TIMER_W-1:0] r_dwell,   n_dwell;
    logic [TIMER_W-1:0] r_timer    [NT];
    logic [TIMER_W-1:0] n_timer    [NT];

    logic [TIMER_W-1:0] period_eff;
    logic [TIMER_W:0]   dwell_inc;
    logic               wrap;
    logic               row_ok;
    logic               row_idle;
    logic [2:0]         col_old;
    logic [2:0]         col_new;

    always_comb begin
        period_eff = (r_col_period == '0) ? TIMER_W'(1) : r_col_period;
        dwell_inc  = {1'b0, r_dwell} + (TIMER_W+1)'(1);
        wrap       = (i_op == OP_TICK) && (dwell_inc >= {1'b0, period_eff});
        row_ok     = (int'(i_row) < ROW_COUNT);
        row_idle   = 1'b0;

        n_dwell  = r_dwell;
        n_column = r_column;
        if (i_op == OP_TICK) begin
            if (wrap) begin
                n_dwell  = '0;
                n_column = (r_column == LAST_COL) ? '0 : r_column + CW'(1);
            end else begin
                n_dwell  = dwell_inc[TIMER_W-1:0];
            end
        end

        for (int r = 0; r < NT; r++) begin
            n_timer[r] = r_timer[r];
            if (i_op == OP_TICK) begin
                if (r_timer[r] != '0) begin
                    n_timer[r] = r_timer[r] - TIMER_W'(1);
                end
            end else if (i_row == ROW_W'(r)) begin
                row_idle   = (r_timer[r] == '0);
                n_timer[r] = r_deb_period;
            end
        end

        col_old = 3'(r_column);
        col_new = 3'(n_column);

        o_result.key_valid       = (i_op == OP_EDGE) && row_ok && row_idle;
        o_result.key_row         = o_result.key_valid ? i_row : '0;
        o_result.key_column      = o_result.key_valid ? col_old[COL_W-1:0] : '0;
        o_result.column_drive    = col_new[2] ? '0 : DRIVE_W'(1) << col_new[1:0];
        o_result.column_advanced = wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_period <= COLUMN_PERIOD_RST;
            r_deb_period <= DEBOUNCE_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COLUMN_PERIOD:   r_col_period <= i_cfg_data;
                CFG_DEBOUNCE_PERIOD: r_deb_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_dwell  <= '0;
            for (int r = 0; r < NT; r++) begin
                r_timer[r] <= '0;
            end
        end else if (i_accept) begin
            r_column <= n_column;
            r_dwell  <= n_dwell;
            for (int r = 0; r < NT; r++) begin
                r_timer[r] <= n_timer[r];
            end
        end
    end

endmodule

// ----- sv/matrix_keypad_scan_debounce.sv -----
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// Keypad matrix scanner with column dwell and per-row debounce.
// ----------------------------------------------------------------------------
// Input stream: one beat per event. tuser[0] is the kind (0 = 1 ms tick,
// 1 = rising edge on a row), tdata[1:0] the row of an edge.
// Output stream: exactly one beat per input beat, in order, with the key
// report, the one-hot column drive after the event and the advance flag.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 = column period, 1 = debounce period) at the clock edge; the user must
// write only while idle, which the block does not enforce.
// Throughput: one beat per cycle while the skid register is empty; the state
// update and the result are one pass of logic into the output register.
// Stall: a skid register holds one more result, so a beat is still taken
// while the output waits; tready drops only when both are full.
// Reset (synchronous, active low): column 0, dwell zero, all row timers
// zero, periods 10 and 200, output empty.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kpsd_pkg::TIMER_W-1:0]        i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [1:0] row_index, rest zero
    input  logic [kpsd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] op
    input  logic [kpsd_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] key_valid, [2:1] key_row, [4:3] key_column, [8:5] column_drive,
    // [9] column_advanced, rest zero
    output logic [kpsd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import kpsd_pkg::*;

    logic    accept;
    logic    out_take;
    t_result result;

    logic    r_out_vld;
    t_result r_out;
    logic    r_skid_vld;
    t_result r_skid;

    assign o_s_axis_tready = !r_skid_vld;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take        = r_out_vld && i_m_axis_tready;

    kpsd_core #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (t_op'(i_s_axis_tuser[0])),
        .i_row       (i_s_axis_tdata[ROW_W-1:0]),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || out_take) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld  <= accept;
                end
            end else if (accept) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_take) begin
            r_out <= r_skid_vld ? r_skid : result;
        end
        if (accept && r_out_vld && !out_take) begin
            r_skid <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W-RESULT_W)'(0), r_out};

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid beat held with output empty");

    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot0(r_out.column_drive))
        else $error("column drive not one-hot");

    a_key_not_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.key_valid) |-> !r_out.column_advanced)
        else $error("key report and column advance in one beat");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_vld && !i_m_axis_tready) |=> r_skid_vld)
        else $error("beat taken during stall was not held");
`endif

endmodule

// ----- tb/kpsd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kpsd_checker
// Scoreboard for the keypad scan and debounce block. It follows the period
// register writes and every accepted input beat. It keeps its own copy of the
// column scan and the row debounce timers, and checks each output beat field
// by field against the oldest predicted report.
// ----------------------------------------------------------------------------
module kpsd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kpsd_pkg::TIMER_W-1:0]     i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    // [1:0] row_index, rest zero
    input  logic [kpsd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] op
    input  logic [kpsd_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] key_valid, [2:1] key_row, [4:3] key_column, [8:5] column_drive,
    // [9] column_advanced, rest zero
    input  logic [kpsd_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_keys,
    output int                               o_advances
);
    import kpsd_pkg::*;

    logic [TIMER_W-1:0] column_period;
    logic [TIMER_W-1:0] debounce_period;
    logic [COL_W-1:0]   active_column;
    int unsigned        dwell_count;
    logic [TIMER_W-1:0] row_timer [ROW_SLOTS];
    t_result            expected_reports [$];
    int                 fails;
    int                 keys;
    int                 advances;

    initial begin
        fails    = 0;
        keys     = 0;
        advances = 0;
    end

    function automatic t_result scan_event(t_op op, logic [ROW_W-1:0] row);
        t_result     rep;
        int unsigned period;
        rep = '0;
        if (op == OP_TICK) begin
            period = (column_period == '0) ? 1 : column_period;
            for (int r = 0; r < ROW_SLOTS; r++) begin
                if (row_timer[r] != '0) begin
                    row_timer[r] = row_timer[r] - 1'b1;
                end
            end
            dwell_count++;
            if (dwell_count >= period) begin
                dwell_count         = 0;
                active_column       = active_column + 1'b1;
                rep.column_advanced = 1'b1;
            end
        end else begin
            if (row_timer[row] == '0) begin
                rep.key_valid  = 1'b1;
                rep.key_row    = row;
                rep.key_column = active_column;
            end
            row_timer[row] = debounce_period;
        end
        rep.column_drive                = '0;
        rep.column_drive[active_column] = 1'b1;
        return rep;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            column_period   = COLUMN_PERIOD_RST;
            debounce_period = DEBOUNCE_PERIOD_RST;
            active_column   = '0;
            dwell_count     = 0;
            for (int r = 0; r < ROW_SLOTS; r++) begin
                row_timer[r] = '0;
            end
            expected_reports.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(i_m_axis_tdata[RESULT_W-1:0]);
                if (got.key_valid) keys++;
                if (got.column_advanced) advances++;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %h", $time,
                             i_m_axis_tdata);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("key_valid", want.key_valid, got.key_valid);
                    check_field("key_row", want.key_row, got.key_row);
                    check_field("key_column", want.key_column, got.key_column);
                    check_field("column_drive", want.column_drive, got.column_drive);
                    check_field("column_advanced", want.column_advanced,
                                got.column_advanced);
                    check_field("tdata padding", 0,
                                i_m_axis_tdata[OUT_TDATA_W-1:RESULT_W]);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COLUMN_PERIOD:   column_period   = i_cfg_data;
                    CFG_DEBOUNCE_PERIOD: debounce_period = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_reports.push_back(scan_event(t_op'(i_s_axis_tuser[0]),
                                                      i_s_axis_tdata[ROW_W-1:0]));
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fails;
        o_keys       <= keys;
        o_advances   <= advances;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for matrix_keypad_scan_debounce. A short directed run covers the
// reset periods, rejected and accepted row edges, zero periods and a period
// lowered below the running dwell. Random phases follow under many period
// settings, with random gaps on both sides, a burst with no idling and a long
// output stall that backs up the input. kpsd_checker does all the checking.
// ----------------------------------------------------------------------------
module tb;
    import kpsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [TIMER_W-1:0]     i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int keys;
    int advances;

    int tx_max_gap   = 11;
    int rx_max_stall = 11;
    bit rx_hold_req  = 1'b0;
    int events_sent  = 0;
    int settings     = 0;

    always #5 i_clk = ~i_clk;

    matrix_keypad_scan_debounce u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    kpsd_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_keys          (keys),
        .o_advances      (advances)
    );

    // one beat; tvalid stays high across back-to-back beats
    task automatic send_event(t_op op, logic [ROW_W-1:0] row);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'(row);
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        events_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_event(OP_TICK, ROW_W'($urandom_range(0, 3)));
    endtask

    // both periods, written only once the output has drained
    task automatic program_periods(logic [TIMER_W-1:0] col, logic [TIMER_W-1:0] deb);
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COLUMN_PERIOD;
        i_cfg_data  <= col;
        @(posedge i_clk);
        i_cfg_index <= CFG_DEBOUNCE_PERIOD;
        i_cfg_data  <= deb;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(logic [TIMER_W-1:0] col, logic [TIMER_W-1:0] deb,
                             int tick_pct, int n);
        t_op op;
        program_periods(col, deb);
        repeat (n) begin
            op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_EDGE;
            send_event(op, ROW_W'($urandom_range(0, 3)));
        end
    endtask

    initial begin : sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                stall       = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run timed out after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset periods: first edge taken, repeat on same row bounced
        send_event(OP_EDGE, 2'd0);
        send_event(OP_EDGE, 2'd0);
        send_event(OP_EDGE, 2'd1);
        send_event(OP_EDGE, 2'd2);
        send_event(OP_EDGE, 2'd3);
        send_ticks(10);
        // advance every tick, no debounce
        program_periods(16'd1, 16'd0);
        send_event(OP_TICK, 2'd3);
        send_event(OP_EDGE, 2'd3);
        send_event(OP_EDGE, 2'd3);
        // zero column period acts as one
        program_periods(16'd0, 16'hFFFF);
        send_ticks(2);
        send_event(OP_EDGE, 2'd2);
        // lower the period below the running dwell
        program_periods(16'hFFFF, 16'd1);
        send_ticks(3);
        program_periods(16'd2, 16'd1);
        send_ticks(1);

        run_phase(16'd3, 16'd5, 60, 80);

        tx_max_gap   = 0;
        rx_max_stall = 0;
        run_phase(16'd1, 16'd0, 50, 60);
        tx_max_gap   = 11;
        rx_max_stall = 11;

        run_phase(16'd0, 16'd2, 50, 60);
        run_phase(16'hFFFF, 16'hFFFF, 40, 50);
        run_phase(TIMER_W'($urandom_range(1, 20)), TIMER_W'($urandom_range(0, 30)),
                  70, 80);

        // long output stall while the input keeps offering
        tx_max_gap  = 0;
        rx_hold_req = 1'b1;
        run_phase(16'd4, 16'd8, 60, 80);
        tx_max_gap  = 11;

        run_phase(16'hFFFF, 16'd3, 80, 40);
        run_phase(16'd2, 16'd3, 60, 40);
        run_phase(TIMER_W'($urandom_range(0, 65535)), TIMER_W'($urandom_range(0, 65535)),
                  60, 60);

        rx_max_stall = 0;
        run_phase(16'd7, 16'd12, 65, 80);
        rx_max_stall = 11;

        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d events over %0d period settings, including a %0d-cycle stall.",
                 events_sent, settings, HOLD_CYCLES);
        $display("Saw %0d key reports and %0d column advances; %0d mismatches.",
                 keys, advances, fail_count);
        if (fail_count + pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
